>>> rtl/hrtt_pkg.sv
// Package for the hash range tablet table: operation and status codes,
// controller/datapath command struct. No dependencies.
package hrtt_pkg;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_DELETE = 3'd1,
    OP_SPLIT  = 3'd2,
    OP_CHANGE = 3'd3,
    OP_READ   = 3'd4,
    OP_WRITE  = 3'd5,
    OP_POINT  = 3'd6,
    OP_EXACT  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_WRONG    = 3'd3,
    ST_OVERLAP  = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  localparam logic [1:0] NORMAL = 2'd0;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture request
    logic search;   // register compare results
    logic update;   // decide and write table
  } cmd_t;

endpackage

>>> rtl/hrtt_datapath.sv
// Datapath of the hash range tablet table: slot storage, parallel compare,
// priority select of hit and free slot, update and result register.
// Depends on hrtt_pkg.
module hrtt_datapath import hrtt_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [2:0]  kind,
  input  logic [63:0] table_id,
  input  logic [63:0] first_hash,
  input  logic [63:0] last_hash,
  input  logic [1:0]  expected_state,
  input  logic [1:0]  given_state,
  output logic [2:0]  res_status,
  output logic [63:0] res_start,
  output logic [63:0] res_end,
  output logic [1:0]  res_state,
  output logic [63:0] res_reads,
  output logic [63:0] res_writes,
  output logic [$clog2(ENTRIES+1)-1:0] res_count
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES+1);

  logic [ENTRIES-1:0] valid;
  logic [63:0] s_table [ENTRIES];
  logic [63:0] s_start [ENTRIES];
  logic [63:0] s_end   [ENTRIES];
  logic [1:0]  s_state [ENTRIES];
  logic [63:0] s_reads [ENTRIES];
  logic [63:0] s_writes[ENTRIES];
  logic [CW-1:0] live;

  op_t         r_kind;
  logic [63:0] r_tab, r_a, r_b;
  logic [1:0]  r_exp, r_giv;

  logic [ENTRIES-1:0] pt_hit, ov_hit;
  logic [IW-1:0] hit_idx, free_idx;
  logic hit_any, ov_any, free_any;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_kind <= op_t'(kind);
      r_tab  <= table_id;
      r_a    <= first_hash;
      r_b    <= last_hash;
      r_exp  <= expected_state;
      r_giv  <= given_state;
    end
  end

  // Compare every slot, register the match vectors
  always_ff @(posedge clk) begin
    if (cmd.search) begin
      for (int i = 0; i < ENTRIES; i++) begin
        pt_hit[i] <= valid[i] && s_table[i] == r_tab &&
                     r_a >= s_start[i] && r_a <= s_end[i];
        ov_hit[i] <= valid[i] && s_table[i] == r_tab &&
                     r_a <= s_end[i] && s_start[i] <= r_b;
      end
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    hit_any  = 1'b0;
    free_any = 1'b0;
    for (int i = ENTRIES-1; i >= 0; i--) begin
      if (pt_hit[i]) begin
        hit_idx = IW'(i);
        hit_any = 1'b1;
      end
      if (!valid[i]) begin
        free_idx = IW'(i);
        free_any = 1'b1;
      end
    end
    ov_any = |ov_hit;
  end

  logic [63:0] h_start, h_end, h_reads, h_writes;
  logic [1:0]  h_state;
  assign h_start  = s_start[hit_idx];
  assign h_end    = s_end[hit_idx];
  assign h_state  = s_state[hit_idx];
  assign h_reads  = s_reads[hit_idx];
  assign h_writes = s_writes[hit_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      live  <= '0;
    end else if (cmd.update) begin
      res_status <= ST_OK;
      res_start  <= '0;
      res_end    <= '0;
      res_state  <= '0;
      res_reads  <= '0;
      res_writes <= '0;
      res_count  <= live;
      unique case (r_kind)
        OP_ADD: begin
          priority if (r_a > r_b) res_status <= ST_MISMATCH;
          else if (ov_any) res_status <= ST_OVERLAP;
          else if (!free_any) res_status <= ST_FULL;
          else begin
            valid[free_idx]    <= 1'b1;
            s_table[free_idx]  <= r_tab;
            s_start[free_idx]  <= r_a;
            s_end[free_idx]    <= r_b;
            s_state[free_idx]  <= r_giv;
            s_reads[free_idx]  <= '0;
            s_writes[free_idx] <= '0;
            live      <= live + 1'b1;
            res_count <= live + 1'b1;
            res_start <= r_a;
            res_end   <= r_b;
            res_state <= r_giv;
          end
        end
        OP_SPLIT: begin
          priority if (!hit_any) res_status <= ST_NOTFOUND;
          else if (r_a == h_start) begin
            res_start  <= h_start;
            res_end    <= h_end;
            res_state  <= h_state;
            res_reads  <= h_reads;
            res_writes <= h_writes;
          end else if (!free_any) res_status <= ST_FULL;
          else begin
            valid[free_idx]    <= 1'b1;
            s_table[free_idx]  <= r_tab;
            s_start[free_idx]  <= r_a;
            s_end[free_idx]    <= h_end;
            s_state[free_idx]  <= h_state;
            s_reads[free_idx]  <= '0;
            s_writes[free_idx] <= '0;
            s_end[hit_idx]     <= r_a - 64'd1;
            s_reads[hit_idx]   <= '0;
            s_writes[hit_idx]  <= '0;
            live      <= live + 1'b1;
            res_count <= live + 1'b1;
            res_start <= r_a;
            res_end   <= h_end;
            res_state <= h_state;
          end
        end
        OP_DELETE, OP_CHANGE, OP_EXACT: begin
          priority if (!hit_any) res_status <= ST_NOTFOUND;
          else if (h_start != r_a || h_end != r_b) res_status <= ST_MISMATCH;
          else begin
            res_start  <= h_start;
            res_end    <= h_end;
            res_state  <= h_state;
            res_reads  <= h_reads;
            res_writes <= h_writes;
            if (r_kind == OP_DELETE) begin
              valid[hit_idx] <= 1'b0;
              live      <= live - 1'b1;
              res_count <= live - 1'b1;
            end else if (r_kind == OP_CHANGE) begin
              if (h_state != r_exp) res_status <= ST_WRONG;
              else begin
                s_state[hit_idx] <= r_giv;
                res_state <= r_giv;
              end
            end
          end
        end
        OP_READ, OP_WRITE, OP_POINT: begin
          if (!hit_any) res_status <= ST_NOTFOUND;
          else begin
            res_start  <= h_start;
            res_end    <= h_end;
            res_state  <= h_state;
            res_reads  <= h_reads;
            res_writes <= h_writes;
            if (r_kind == OP_READ) begin
              if (h_state != NORMAL) res_status <= ST_WRONG;
              else begin
                s_reads[hit_idx] <= h_reads + 64'd1;
                res_reads <= h_reads + 64'd1;
              end
            end else if (r_kind == OP_WRITE) begin
              s_writes[hit_idx] <= h_writes + 64'd1;
              res_writes <= h_writes + 64'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/hrtt_ctrl.sv
// Controller of the hash range tablet table: sequences load, compare,
// update and result hand-off. Depends on hrtt_pkg.
module hrtt_ctrl import hrtt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  typedef enum logic [1:0] {IDLE, SEARCH, UPDATE, DONE} state_t;
  state_t state;

  assign in_stall   = (state != IDLE);
  assign cmd.load   = (state == IDLE) && in_valid;
  assign cmd.search = (state == SEARCH);
  assign cmd.update = (state == UPDATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE:   if (in_valid) state <= SEARCH;
        SEARCH: state <= UPDATE;
        UPDATE: begin
          state     <= DONE;
          out_valid <= 1'b1;
        end
        DONE: if (!out_stall) begin
          state     <= IDLE;
          out_valid <= 1'b0;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> rtl/hash_range_tablet_table_unit.sv
// Top level of the hash range tablet table: controller plus datapath.
// Depends on hrtt_pkg, hrtt_ctrl, hrtt_datapath.
//
// Usage: present a request on in_valid with kind, table_id, first_hash,
// last_hash, expected_state and given_state; it is taken when in_stall is
// low. One result per request appears on out_valid with status, hit fields
// and tablet_count, held until out_stall is low.
// The item is first captured in the input registers; then the compare of all
// slots is registered in parallel (SEARCH); then one slot is selected and
// updated and the result register is loaded (UPDATE), and out_valid rises.
// A new item is taken only once the result of the last one has been
// delivered and the controller is back in IDLE, so items never overlap.
// Reset (rst, synchronous) marks every slot empty and clears the count;
// slot contents are left as they are. While the receiver stalls, the
// result holds and no new item is taken.
module hash_range_tablet_table_unit import hrtt_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [63:0] table_id,
  input  logic [63:0] first_hash,
  input  logic [63:0] last_hash,
  input  logic [1:0]  expected_state,
  input  logic [1:0]  given_state,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [63:0] hit_start,
  output logic [63:0] hit_end,
  output logic [1:0]  hit_state,
  output logic [63:0] hit_reads,
  output logic [63:0] hit_writes,
  output logic [$clog2(ENTRIES+1)-1:0] tablet_count
);

  cmd_t cmd;

  hrtt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd
  );

  hrtt_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk, .rst, .cmd, .kind, .table_id, .first_hash, .last_hash,
    .expected_state, .given_state,
    .res_status(status), .res_start(hit_start), .res_end(hit_end),
    .res_state(hit_state), .res_reads(hit_reads), .res_writes(hit_writes),
    .res_count(tablet_count)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("item taken while result pending");

  a_result_timing: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> ##2 out_valid)
    else $error("result not ready three cycles after accept");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tablet_count <= ($clog2(ENTRIES+1))'(ENTRIES))
    else $error("tablet count beyond table size");

endmodule

>>> dv/tb_top.sv
// Testbench for hash_range_tablet_table_unit: directed and random table operations
// checked against a scoreboard that tracks the tablet table. Depends on hrtt_pkg.
`timescale 1ns / 100ps

module tb_top;
  import hrtt_pkg::*;

  localparam int SLOTS = 64;

  typedef struct packed {
    status_t     status;
    logic [63:0] hit_start;
    logic [63:0] hit_end;
    logic [1:0]  hit_state;
    logic [63:0] hit_reads;
    logic [63:0] hit_writes;
    logic [6:0]  tablet_count;
  } table_reply_t;

  class tablet_scoreboard;
    bit           used [SLOTS];
    bit [63:0]    tab [SLOTS];
    bit [63:0]    lo [SLOTS];
    bit [63:0]    hi [SLOTS];
    bit [1:0]     st [SLOTS];
    bit [63:0]    rd [SLOTS];
    bit [63:0]    wr [SLOTS];
    int           live;
    table_reply_t pending [$];
    int           errors;
    int           checked;
    int           full_seen;

    function int find_point(bit [63:0] t, bit [63:0] h);
      for (int i = 0; i < SLOTS; i++)
        if (used[i] && tab[i] == t && h >= lo[i] && h <= hi[i]) return i;
      return -1;
    endfunction

    function int find_free();
      for (int i = 0; i < SLOTS; i++)
        if (!used[i]) return i;
      return -1;
    endfunction

    function void show(inout table_reply_t r, input int s);
      r.hit_start  = lo[s];
      r.hit_end    = hi[s];
      r.hit_state  = st[s];
      r.hit_reads  = rd[s];
      r.hit_writes = wr[s];
    endfunction

    function void place(int s, bit [63:0] t, bit [63:0] a, bit [63:0] b, bit [1:0] g);
      used[s] = 1; tab[s] = t; lo[s] = a; hi[s] = b; st[s] = g;
      rd[s] = '0; wr[s] = '0;
      live++;
    endfunction

    // Predict the reply of one accepted item and update the table copy.
    function void note_item(op_t k, bit [63:0] t, bit [63:0] a, bit [63:0] b,
                            bit [1:0] e, bit [1:0] g);
      table_reply_t r;
      int s;
      int f;
      int hit;
      r = '0;
      r.status = ST_OK;
      case (k)
        OP_ADD: begin
          hit = -1;
          for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && used[i] && tab[i] == t && a <= hi[i] && lo[i] <= b) hit = i;
          f = find_free();
          if (a > b) r.status = ST_MISMATCH;
          else if (hit >= 0) r.status = ST_OVERLAP;
          else if (f < 0) r.status = ST_FULL;
          else begin
            place(f, t, a, b, g);
            show(r, f);
          end
        end
        OP_DELETE, OP_CHANGE, OP_EXACT: begin
          s = find_point(t, a);
          if (s < 0) r.status = ST_NOTFOUND;
          else if (lo[s] != a || hi[s] != b) r.status = ST_MISMATCH;
          else if (k == OP_DELETE) begin
            show(r, s);
            used[s] = 0;
            live--;
          end else if (k == OP_CHANGE) begin
            if (st[s] != e) r.status = ST_WRONG;
            else st[s] = g;
            show(r, s);
          end else show(r, s);
        end
        OP_SPLIT: begin
          s = find_point(t, a);
          f = find_free();
          if (s < 0) r.status = ST_NOTFOUND;
          else if (a == lo[s]) show(r, s);
          else if (f < 0) r.status = ST_FULL;
          else begin
            place(f, t, a, hi[s], st[s]);
            hi[s] = a - 64'd1;
            rd[s] = '0;
            wr[s] = '0;
            show(r, f);
          end
        end
        OP_READ: begin
          s = find_point(t, a);
          if (s < 0) r.status = ST_NOTFOUND;
          else begin
            if (st[s] != NORMAL) r.status = ST_WRONG;
            else rd[s]++;
            show(r, s);
          end
        end
        OP_WRITE: begin
          s = find_point(t, a);
          if (s < 0) r.status = ST_NOTFOUND;
          else begin
            wr[s]++;
            show(r, s);
          end
        end
        default: begin
          s = find_point(t, a);
          if (s < 0) r.status = ST_NOTFOUND;
          else show(r, s);
        end
      endcase
      if (r.status == ST_FULL) full_seen++;
      r.tablet_count = live[6:0];
      pending = {pending, r};
    endfunction

    function void check_result(table_reply_t got);
      table_reply_t w;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, got.status);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) begin
        $display("%0t: status exp %0d got %0d", $time, w.status, got.status); errors++;
      end
      if (got.hit_start !== w.hit_start) begin
        $display("%0t: hit_start exp %h got %h", $time, w.hit_start, got.hit_start); errors++;
      end
      if (got.hit_end !== w.hit_end) begin
        $display("%0t: hit_end exp %h got %h", $time, w.hit_end, got.hit_end); errors++;
      end
      if (got.hit_state !== w.hit_state) begin
        $display("%0t: hit_state exp %0d got %0d", $time, w.hit_state, got.hit_state); errors++;
      end
      if (got.hit_reads !== w.hit_reads) begin
        $display("%0t: hit_reads exp %h got %h", $time, w.hit_reads, got.hit_reads); errors++;
      end
      if (got.hit_writes !== w.hit_writes) begin
        $display("%0t: hit_writes exp %h got %h", $time, w.hit_writes, got.hit_writes);
        errors++;
      end
      if (got.tablet_count !== w.tablet_count) begin
        $display("%0t: tablet_count exp %0d got %0d", $time, w.tablet_count,
                 got.tablet_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  kind;
  logic [63:0] table_id;
  logic [63:0] first_hash;
  logic [63:0] last_hash;
  logic [1:0]  expected_state;
  logic [1:0]  given_state;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [63:0] hit_start;
  logic [63:0] hit_end;
  logic [1:0]  hit_state;
  logic [63:0] hit_reads;
  logic [63:0] hit_writes;
  logic [6:0]  tablet_count;

  tablet_scoreboard sb;
  int snd_idle;
  int rcv_idle;
  int items_sent;

  hash_range_tablet_table_unit #(.ENTRIES(SLOTS)) uut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver stall, redrawn every cycle.
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      out_stall <= ($urandom_range(0, 99) < rcv_idle);
    end
  end

  // Sample at the falling edge; a result seen here is taken at the next rising edge.
  initial begin
    table_reply_t got;
    forever begin
      @(negedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.status       = status_t'(status);
        got.hit_start    = hit_start;
        got.hit_end      = hit_end;
        got.hit_state    = hit_state;
        got.hit_reads    = hit_reads;
        got.hit_writes   = hit_writes;
        got.tablet_count = tablet_count;
        sb.check_result(got);
      end
    end
  end

  task automatic send(op_t k, bit [63:0] t, bit [63:0] a, bit [63:0] b,
                      bit [1:0] e, bit [1:0] g);
    bit taken;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid       <= 1;
    kind           <= k;
    table_id       <= t;
    first_hash     <= a;
    last_hash      <= b;
    expected_state <= e;
    given_state    <= g;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sb.note_item(k, t, a, b, e, g);
    items_sent++;
  endtask

  // Hold the sender until every reply is back.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic bit [63:0] pick_table();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 64'($urandom_range(1, 3));
    if (r < 88) return 64'd0;
    if (r < 94) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic random_item();
    op_t         k;
    bit [63:0]   t, a, b, span;
    int          r, s, tries;
    r = $urandom_range(0, 99);
    if (r < 30) k = OP_ADD;
    else if (r < 42) k = OP_DELETE;
    else if (r < 57) k = OP_SPLIT;
    else if (r < 67) k = OP_CHANGE;
    else if (r < 79) k = OP_READ;
    else if (r < 89) k = OP_WRITE;
    else if (r < 94) k = OP_POINT;
    else k = OP_EXACT;
    t = pick_table();
    a = 64'($urandom_range(0, 3000));
    b = a + 64'($urandom_range(0, 200));
    if (k == OP_ADD) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        if (a > b) begin span = a; a = b; b = span; end
      end else if (r < 13) begin
        b = a - 64'($urandom_range(1, 5));
      end
    end else if ($urandom_range(0, 99) < 75 && sb.live > 0) begin
      // Aim at an existing tablet.
      s = $urandom_range(0, SLOTS - 1);
      for (tries = 0; !sb.used[s]; tries++) s = (s + 1) % SLOTS;
      t = sb.tab[s];
      a = sb.lo[s];
      b = sb.hi[s];
      span = b - a + 64'd1;
      r = $urandom_range(0, 99);
      if (k == OP_SPLIT || k == OP_READ || k == OP_WRITE || k == OP_POINT) begin
        if (r < 75) a = (span == 0) ? {$urandom, $urandom} : a + ({$urandom, $urandom} % span);
      end else if (r < 15) begin
        b = b + 64'd1;
      end else if (r < 22 && span > 1) begin
        a = a + 64'd1;
      end
      if (k == OP_CHANGE && $urandom_range(0, 99) < 65) begin
        send(k, t, a, b, sb.st[s], 2'($urandom));
        return;
      end
    end else if ($urandom_range(0, 99) < 5) begin
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
    end
    send(k, t, a, b, 2'($urandom), 2'($urandom));
  endtask

  localparam bit [63:0] ALL = '1;

  initial begin
    int quota;
    sb = new();
    rst = 1;
    in_valid = 0;
    kind = OP_POINT;
    table_id = '0;
    first_hash = '0;
    last_hash = '0;
    expected_state = NORMAL;
    given_state = NORMAL;
    items_sent = 0;
    snd_idle = 34;
    rcv_idle = 82;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(OP_ADD, ALL, 64'd0, ALL, 2'd0, NORMAL);
    send(OP_POINT, ALL, ALL, 64'd0, 2'd0, 2'd0);
    send(OP_ADD, ALL, 64'd5, 64'd9, 2'd0, 2'd0);       // overlap
    send(OP_ADD, 64'd0, 64'd10, 64'd9, 2'd0, 2'd0);    // inverted range
    send(OP_ADD, 64'd0, 64'd0, 64'd0, 2'd3, 2'd3);
    send(OP_ADD, 64'd1, ALL, ALL, 2'd0, 2'd1);
    send(OP_READ, ALL, 64'd77, 64'd0, 2'd0, 2'd0);
    send(OP_WRITE, ALL, 64'd0, 64'd0, 2'd0, 2'd0);
    send(OP_READ, 64'd1, ALL, 64'd0, 2'd0, 2'd0);      // not normal
    send(OP_CHANGE, 64'd1, ALL, ALL, 2'd0, 2'd2);      // wrong state
    send(OP_CHANGE, 64'd1, ALL, ALL, 2'd1, NORMAL);
    send(OP_CHANGE, 64'd0, 64'd0, 64'd1, 2'd3, 2'd0);  // range mismatch
    send(OP_SPLIT, ALL, 64'd0, 64'd0, 2'd0, 2'd0);     // at start, no change
    send(OP_SPLIT, ALL, 64'h8000_0000_0000_0000, 64'd0, 2'd0, 2'd0);
    send(OP_SPLIT, 64'd2, 64'd4, 64'd0, 2'd0, 2'd0);   // not found
    send(OP_EXACT, ALL, 64'h8000_0000_0000_0000, ALL, 2'd0, 2'd0);
    send(OP_EXACT, ALL, 64'd0, ALL, 2'd0, 2'd0);
    send(OP_DELETE, ALL, 64'd0, 64'd5, 2'd0, 2'd0);
    send(OP_DELETE, ALL, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 2'd0, 2'd0);
    send(OP_DELETE, ALL, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 2'd0, 2'd0);
    send(OP_POINT, 64'd0, 64'd1, 64'd0, 2'd0, 2'd0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 34 : (ph == 1) ? 82 : 0;
      rcv_idle = (ph == 0) ? 82 : (ph == 1) ? 34 : 0;
      quota = (ph == 2) ? 480 : 410;
      for (int n = 0; n < quota; n++) begin
        // Occasionally run into stretches with no idling at all.
        if (n % 100 == 50) begin snd_idle = 0; rcv_idle = 0; end
        if (n % 100 == 70) begin
          snd_idle = (ph == 0) ? 34 : (ph == 1) ? 82 : 0;
          rcv_idle = (ph == 0) ? 82 : (ph == 1) ? 34 : 0;
        end
        random_item();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d items, checked %0d replies, %0d table-full replies, %0d live at end",
             items_sent, sb.checked, sb.full_seen, sb.live);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
